[rtl/uclr_pkg.sv]
// ------------------------------------------------------------
// uclr_pkg
// shared types and constants of the unique class label resolver
// ------------------------------------------------------------
package uclr_pkg;

  // fixed field widths of the channels
  localparam int SCORE_W = 16;
  localparam int CELL_W  = 4;
  localparam int LABEL_W = 4;

  // command control from front to back
  typedef struct packed {
    logic wr;    // store the score at the carried address
    logic last;  // table complete, start resolution
  } uclr_ctl_t;

  // back status seen by the top level
  typedef struct packed {
    logic idle;  // waiting for a command
    logic emit;  // handing out results
  } uclr_bk_stat_t;

endpackage

[rtl/uclr_if.sv]
// ------------------------------------------------------------
// uclr_if
// valid/ready channel interfaces for scores and results
// ------------------------------------------------------------
interface uclr_in_if;
  import uclr_pkg::*;

  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               last_score;

  modport source (output valid, output score, output last_score, input ready);
  modport sink   (input valid, input score, input last_score, output ready);
endinterface

interface uclr_out_if;
  import uclr_pkg::*;

  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  cell_res;
  logic [LABEL_W-1:0] label;
  logic               last_cell;

  modport source (output valid, output cell_res, output label, output last_cell,
                  input ready);
  modport sink   (input valid, input cell_res, input label, input last_cell,
                  output ready);
endinterface

[rtl/uclr_front.sv]
// ------------------------------------------------------------
// uclr_front
// accepts scores, assigns table addresses and tags the end mark
// ------------------------------------------------------------
module uclr_front #(
  parameter int NUM_CELLS  = 9,
  parameter int SCORE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  uclr_in_if.sink                                   in_ch,
  input  logic                                      q_full,
  output logic                                      q_push,
  output uclr_pkg::uclr_ctl_t                       q_ctl,
  output logic [$clog2(NUM_CELLS*NUM_CELLS)-1:0]    q_addr,
  output logic [SCORE_BITS-1:0]                     q_data
);
  import uclr_pkg::*;

  localparam int TBL = NUM_CELLS * NUM_CELLS;
  localparam int AW  = $clog2(TBL);
  localparam int LCW = $clog2(TBL + 1);

  logic [LCW-1:0] load_cnt_r, load_cnt_nxt;
  logic           room;

  // keep the low score bits, zero-extend when storage is wider
  if (SCORE_BITS <= SCORE_W) begin : g_trunc
    assign q_data = in_ch.score[SCORE_BITS-1:0];
  end else begin : g_ext
    assign q_data = {{(SCORE_BITS-SCORE_W){1'b0}}, in_ch.score};
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign room        = load_cnt_r < LCW'(TBL);
  assign q_ctl.wr    = room;
  assign q_ctl.last  = in_ch.last_score;
  assign q_addr      = load_cnt_r[AW-1:0];

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (q_push) begin
      if (in_ch.last_score) begin
        load_cnt_nxt = '0;
      end else if (room) begin
        load_cnt_nxt = load_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

endmodule

[rtl/uclr_queue.sv]
// ------------------------------------------------------------
// uclr_queue
// two-entry command queue between front and back
// ------------------------------------------------------------
module uclr_queue #(
  parameter int W = 23
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  uclr_pkg::uclr_ctl_t din_ctl,
  input  logic [W-1:0]        din_data,
  output logic                full,
  input  logic                pop,
  output uclr_pkg::uclr_ctl_t dout_ctl,
  output logic [W-1:0]        dout_data,
  output logic                empty
);
  import uclr_pkg::*;

  localparam int QD   = 2;
  localparam int CNTW = $clog2(QD + 1);

  uclr_ctl_t       ctl_q  [QD];
  logic [W-1:0]    data_q [QD];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CNTW'(QD);
  assign empty     = cnt_r == '0;
  assign dout_ctl  = ctl_q[rd_ptr_r];
  assign dout_data = data_q[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr_r]  <= din_ctl;
      data_q[wr_ptr_r] <= din_data;
    end
  end

endmodule

[rtl/uclr_back.sv]
// ------------------------------------------------------------
// uclr_back
// score table, conflict-resolution sequencer and result output
// ------------------------------------------------------------
module uclr_back #(
  parameter int NUM_CELLS  = 9,
  parameter int SCORE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  uclr_pkg::uclr_ctl_t                    q_ctl,
  input  logic [$clog2(NUM_CELLS*NUM_CELLS)-1:0] q_addr,
  input  logic [SCORE_BITS-1:0]                  q_data,
  output logic                                   q_pop,
  output uclr_pkg::uclr_bk_stat_t                bk_stat,
  uclr_out_if.source                             out_ch
);
  import uclr_pkg::*;

  localparam int TBL = NUM_CELLS * NUM_CELLS;
  localparam int AW  = $clog2(TBL);
  localparam int CW  = $clog2(NUM_CELLS);
  localparam int IW  = $clog2(NUM_CELLS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_DUEL   = 5'b01000,
    ST_EMIT   = 5'b10000
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  logic [SCORE_BITS-1:0] mem [TBL];
  logic                  mem_we;
  logic [AW-1:0]         raddr;
  logic [SCORE_BITS-1:0] rdata_r;

  logic [CW-1:0]         cell_i_r, cell_i_nxt;
  logic [CW-1:0]         cur_r, cur_nxt;
  logic [IW-1:0]         iss_r, iss_nxt;
  logic                  rdv_r, rdv_nxt;
  logic [CW-1:0]         rdcls_r, rdcls_nxt;
  logic                  any_r, any_nxt;
  logic [CW-1:0]         best_c_r, best_c_nxt;
  logic [SCORE_BITS-1:0] best_s_r, best_s_nxt;
  logic [CW-1:0]         own_r, own_nxt;
  logic [CW-1:0]         emit_k_r, emit_k_nxt;
  logic [NUM_CELLS-1:0]  excl_r [NUM_CELLS];
  logic [NUM_CELLS-1:0]  excl_nxt [NUM_CELLS];
  logic [NUM_CELLS-1:0]  owned_r, owned_nxt;
  logic [CW-1:0]         owner_r [NUM_CELLS];
  logic [CW-1:0]         owner_nxt [NUM_CELLS];
  logic [CW-1:0]         label_r [NUM_CELLS];
  logic [CW-1:0]         label_nxt [NUM_CELLS];

  logic                  out_v_r, out_v_nxt;
  logic [CELL_W-1:0]     out_cell_r, out_cell_nxt;
  logic [LABEL_W-1:0]    out_label_r, out_label_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  cell_done;
  logic [CW-1:0]         loser;

  function automatic logic [AW-1:0] tbl_addr(input logic [CW-1:0] cell_no,
                                             input logic [CW-1:0] cls);
    return AW'(cell_no * NUM_CELLS + cls);
  endfunction

  assign bk_stat.idle    = state_r == ST_IDLE;
  assign bk_stat.emit    = state_r == ST_EMIT;
  assign out_ch.valid    = out_v_r;
  assign out_ch.cell_res = out_cell_r;
  assign out_ch.label    = out_label_r;
  assign out_ch.last_cell = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    cell_i_nxt    = cell_i_r;
    cur_nxt       = cur_r;
    iss_nxt       = iss_r;
    rdv_nxt       = 1'b0;
    rdcls_nxt     = rdcls_r;
    any_nxt       = any_r;
    best_c_nxt    = best_c_r;
    best_s_nxt    = best_s_r;
    own_nxt       = own_r;
    emit_k_nxt    = emit_k_r;
    excl_nxt      = excl_r;
    owned_nxt     = owned_r;
    owner_nxt     = owner_r;
    label_nxt     = label_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_cell_nxt  = out_cell_r;
    out_label_nxt = out_label_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    raddr         = '0;
    q_pop         = 1'b0;
    cell_done     = 1'b0;
    loser         = cur_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          mem_we = q_ctl.wr;
          if (q_ctl.last) begin
            owned_nxt = '0;
            for (int j = 0; j < NUM_CELLS; j++) begin
              excl_nxt[j] = '0;
            end
            cell_i_nxt = '0;
            cur_nxt    = '0;
            iss_nxt    = '0;
            any_nxt    = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read one class score a cycle, compare in the next cycle
        if (iss_r != IW'(NUM_CELLS)) begin
          raddr     = tbl_addr(cur_r, CW'(iss_r));
          iss_nxt   = iss_r + 1'b1;
          rdv_nxt   = 1'b1;
          rdcls_nxt = CW'(iss_r);
        end
        if (rdv_r) begin
          if (!excl_r[cur_r][rdcls_r] && (!any_r || rdata_r > best_s_r)) begin
            any_nxt    = 1'b1;
            best_c_nxt = rdcls_r;
            best_s_nxt = rdata_r;
          end
          if (rdcls_r == CW'(NUM_CELLS - 1)) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (!any_r) begin
          label_nxt[cur_r] = '0;
          cell_done        = 1'b1;
        end else begin
          label_nxt[cur_r] = best_c_r;
          if (!owned_r[best_c_r]) begin
            owned_nxt[best_c_r] = 1'b1;
            owner_nxt[best_c_r] = cur_r;
            cell_done           = 1'b1;
          end else begin
            // fetch the owner's score for the contested class
            raddr     = tbl_addr(owner_r[best_c_r], best_c_r);
            own_nxt   = owner_r[best_c_r];
            state_nxt = ST_DUEL;
          end
        end
      end
      ST_DUEL: begin
        if (rdata_r > best_s_r) begin
          loser = cur_r;
        end else begin
          owner_nxt[best_c_r] = cur_r;
          loser               = own_r;
        end
        excl_nxt[loser][best_c_r] = 1'b1;
        cur_nxt   = loser;
        iss_nxt   = '0;
        any_nxt   = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_EMIT: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt     = 1'b1;
          out_cell_nxt  = CELL_W'(emit_k_r);
          out_label_nxt = LABEL_W'(label_r[emit_k_r]);
          out_last_nxt  = emit_k_r == CW'(NUM_CELLS - 1);
          if (emit_k_r == CW'(NUM_CELLS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_k_nxt = emit_k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cell_done) begin
      if (cell_i_r == CW'(NUM_CELLS - 1)) begin
        emit_k_nxt = '0;
        state_nxt  = ST_EMIT;
      end else begin
        cell_i_nxt = cell_i_r + 1'b1;
        cur_nxt    = cell_i_r + 1'b1;
        iss_nxt    = '0;
        any_nxt    = 1'b0;
        state_nxt  = ST_SCAN;
      end
    end
  end

  // score table, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_addr] <= q_data;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rdv_r   <= 1'b0;
      out_v_r <= 1'b0;
      owned_r <= '0;
      for (int j = 0; j < NUM_CELLS; j++) begin
        excl_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      out_v_r <= out_v_nxt;
      owned_r <= owned_nxt;
      excl_r  <= excl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_i_r    <= cell_i_nxt;
    cur_r       <= cur_nxt;
    iss_r       <= iss_nxt;
    rdcls_r     <= rdcls_nxt;
    any_r       <= any_nxt;
    best_c_r    <= best_c_nxt;
    best_s_r    <= best_s_nxt;
    own_r       <= own_nxt;
    emit_k_r    <= emit_k_nxt;
    owner_r     <= owner_nxt;
    label_r     <= label_nxt;
    out_cell_r  <= out_cell_nxt;
    out_label_r <= out_label_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

[rtl/unique_class_label_resolver_core.sv]
// ------------------------------------------------------------
// unique_class_label_resolver_core
// loads a cell-by-class score table and gives each cell a unique label
// ------------------------------------------------------------
// Scores arrive one per transfer on in_ch, cell-major then class, and are
// written into an internal table of NUM_CELLS*NUM_CELLS entries; a transfer
// with last_score set ends the table and starts resolution, and scores past
// a full table are dropped. Loading runs at one score per cycle through a
// two-entry command queue. Resolution is a sequencer over the single table
// read port: each pick of a cell scans its NUM_CELLS classes, and each
// ownership conflict adds a read of the owner's score for the contested
// class and a duel before the loser picks again. A run takes P picks and C
// conflicts (P = NUM_CELLS + C, C at most NUM_CELLS*(NUM_CELLS-1)). During
// that walk the queue fills and in_ch stalls. Then NUM_CELLS results leave
// out_ch, one per cycle when the sink is ready, cells in order, last_cell on
// the final one. Table entries not rewritten in a run keep their earlier
// contents.
// ------------------------------------------------------------
module unique_class_label_resolver_core #(
  parameter int NUM_CELLS  = 9,
  parameter int SCORE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  uclr_in_if.sink    in_ch,
  uclr_out_if.source out_ch
);
  import uclr_pkg::*;

  localparam int AW = $clog2(NUM_CELLS * NUM_CELLS);
  localparam int QW = AW + SCORE_BITS;

  // front side of the queue
  logic                  f_push;
  uclr_ctl_t             f_ctl;
  logic [AW-1:0]         f_addr;
  logic [SCORE_BITS-1:0] f_data;
  logic                  q_full;

  // back side of the queue
  logic                  q_pop;
  logic                  q_empty;
  uclr_ctl_t             q_ctl;
  logic [QW-1:0]         q_word;

  uclr_bk_stat_t         bk_stat;

  // accepts scores and numbers them into table addresses
  uclr_front #(
    .NUM_CELLS  (NUM_CELLS),
    .SCORE_BITS (SCORE_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (f_push),
    .q_ctl  (f_ctl),
    .q_addr (f_addr),
    .q_data (f_data)
  );

  // decouples loading from the resolution walk
  uclr_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .din_ctl   (f_ctl),
    .din_data  ({f_addr, f_data}),
    .full      (q_full),
    .pop       (q_pop),
    .dout_ctl  (q_ctl),
    .dout_data (q_word),
    .empty     (q_empty)
  );

  // table storage, label resolution and result output
  uclr_back #(
    .NUM_CELLS  (NUM_CELLS),
    .SCORE_BITS (SCORE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_ctl   (q_ctl),
    .q_addr  (q_word[QW-1:SCORE_BITS]),
    .q_data  (q_word[SCORE_BITS-1:0]),
    .q_pop   (q_pop),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

  // front never overruns the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> !q_full)
    else $error("command pushed into a full queue");

  // back never takes a command that is not there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && bk_stat.idle)
    else $error("command popped from an empty queue or while busy");

  // a new result burst only follows the emit phase
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !$past(out_ch.valid)) |-> $past(bk_stat.emit))
    else $error("result appeared outside the emit phase");

endmodule
